// ===== src/lfnr_pkg.sv =====
// Package for the linked-list FIFO with node recycling.
// Holds the state encoding, status codes and result field widths.
// No dependencies.
`default_nettype none

package lfnr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_VALUE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STATUS_ENQUEUED  = 2'd0,
        STATUS_DEQUEUED  = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_EXHAUSTED = 2'd3
    } status_t;

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    localparam int VALUE_FIELD_BITS = 32;
    localparam int COUNT_FIELD_BITS = 7;
    localparam int STAT_FIELD_BITS  = 32;
    localparam int RESULT_BITS      = 152;

endpackage

`default_nettype wire

// ===== src/linked_fifo_with_node_recycling_core.sv =====
// Top level of the linked-list FIFO with node recycling.
// Keeps links and values in two single-port synchronous memories.
// Depends on lfnr_pkg.
//
//  channel | direction | tdata                         | tuser
//  s_*     | in        | value_in                      | mode
//  m_*     | out       | value_out, counts, statistics | status
//
// A fresh-slot enqueue, an empty dequeue or a refused enqueue goes straight
// to ST_DONE; an enqueue from the free list passes through ST_LINK, a dequeue
// through ST_LINK and ST_VALUE for the dependent link and value memory reads.
// A finished word waits in the output register while the next word is
// taken. Reset leaves both lists empty and needs no clearing pass.
`default_nettype none

module linked_fifo_with_node_recycling_core #(
    parameter int NODE_SLOTS = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // value_in
    input  wire logic [0:0]   s_tuser,   // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // value_out, free_length, free_peak, nodes_made, nodes_reused,
    // free_pushes, free_pops, zero fill
    output logic [151:0]      m_tdata,
    output logic [1:0]        m_tuser    // status
);

    localparam int PTR_W      = $clog2(NODE_SLOTS);
    localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
    localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int CW         = lfnr_pkg::COUNT_FIELD_BITS;
    localparam int VW         = lfnr_pkg::VALUE_FIELD_BITS;

    logic [PTR_W-1:0]      link_mem [NODE_SLOTS];
    logic [STORE_BITS-1:0] value_mem [NODE_SLOTS];

    lfnr_pkg::state_t  state_reg, state_next;
    lfnr_pkg::status_t status_reg, status_next;

    logic                  mode_reg, mode_next;
    logic [STORE_BITS-1:0] val_reg, val_next;
    logic [STORE_BITS-1:0] vout_reg, vout_next;
    logic [PTR_W-1:0]      qhead_reg, qhead_next;
    logic [PTR_W-1:0]      qtail_reg, qtail_next;
    logic [PTR_W-1:0]      fhead_reg, fhead_next;
    logic [PTR_W-1:0]      ftail_reg, ftail_next;
    logic [CNT_W-1:0]      fcount_reg, fcount_next;
    logic [CNT_W-1:0]      fmax_reg, fmax_next;
    logic [CNT_W-1:0]      made_reg, made_next;
    logic [31:0]           reuse_reg, reuse_next;
    logic [31:0]           push_reg, push_next;
    logic [31:0]           pop_reg, pop_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [151:0]          m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;

    logic                  link_en, link_we;
    logic [PTR_W-1:0]      link_addr, link_wdata;
    logic [PTR_W-1:0]      link_rdata_reg;
    logic                  value_en, value_we;
    logic [PTR_W-1:0]      value_addr;
    logic [STORE_BITS-1:0] value_wdata;
    logic [STORE_BITS-1:0] value_rdata_reg;

    logic [CNT_W+CW-1:0]   fcount_wide, fmax_wide, made_wide;
    logic [STORE_BITS+VW-1:0] vout_wide;
    logic [CNT_W-1:0]      fcount_inc;
    logic                  out_free;

    always_ff @(posedge clk)
    begin
        if (link_en)
        begin
            if (link_we)
            begin
                link_mem[link_addr] <= link_wdata;
            end
            link_rdata_reg <= link_mem[link_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_en)
        begin
            if (value_we)
            begin
                value_mem[value_addr] <= value_wdata;
            end
            value_rdata_reg <= value_mem[value_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lfnr_pkg::ST_IDLE;
            qhead_reg    <= '0;
            qtail_reg    <= '0;
            fhead_reg    <= PTR_W'(1);
            ftail_reg    <= PTR_W'(1);
            fcount_reg   <= '0;
            fmax_reg     <= '0;
            made_reg     <= CNT_W'(2);
            reuse_reg    <= '0;
            push_reg     <= '0;
            pop_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            qhead_reg    <= qhead_next;
            qtail_reg    <= qtail_next;
            fhead_reg    <= fhead_next;
            ftail_reg    <= ftail_next;
            fcount_reg   <= fcount_next;
            fmax_reg     <= fmax_next;
            made_reg     <= made_next;
            reuse_reg    <= reuse_next;
            push_reg     <= push_next;
            pop_reg      <= pop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        mode_reg    <= mode_next;
        val_reg     <= val_next;
        vout_reg    <= vout_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign fcount_wide = {{CW{1'b0}}, fcount_reg};
    assign fmax_wide   = {{CW{1'b0}}, fmax_reg};
    assign made_wide   = {{CW{1'b0}}, made_reg};
    assign vout_wide   = {{VW{1'b0}}, vout_reg};
    assign fcount_inc  = fcount_reg + CNT_W'(1);
    assign out_free    = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        mode_next     = mode_reg;
        val_next      = val_reg;
        vout_next     = vout_reg;
        qhead_next    = qhead_reg;
        qtail_next    = qtail_reg;
        fhead_next    = fhead_reg;
        ftail_next    = ftail_reg;
        fcount_next   = fcount_reg;
        fmax_next     = fmax_reg;
        made_next     = made_reg;
        reuse_next    = reuse_reg;
        push_next     = push_reg;
        pop_next      = pop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        link_en       = 1'b0;
        link_we       = 1'b0;
        link_addr     = qtail_reg;
        link_wdata    = made_reg[PTR_W-1:0];
        value_en      = 1'b0;
        value_we      = 1'b0;
        value_addr    = made_reg[PTR_W-1:0];
        value_wdata   = s_tdata[STORE_BITS-1:0];
        s_tready      = 1'b0;

        unique case (state_reg)
            lfnr_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                mode_next = s_tuser[0];
                val_next  = s_tdata[STORE_BITS-1:0];
                vout_next = '0;
                if (s_tvalid)
                begin
                    if (s_tuser[0] == lfnr_pkg::MODE_ENQUEUE)
                    begin
                        pop_next = pop_reg + 32'd1;
                        if (fcount_reg != '0)
                        begin
                            link_en    = 1'b1;
                            link_addr  = fhead_reg;
                            state_next = lfnr_pkg::ST_LINK;
                        end
                        else if (made_reg < CNT_W'(NODE_SLOTS))
                        begin
                            value_en    = 1'b1;
                            value_we    = 1'b1;
                            link_en     = 1'b1;
                            link_we     = 1'b1;
                            made_next   = made_reg + CNT_W'(1);
                            qtail_next  = made_reg[PTR_W-1:0];
                            status_next = lfnr_pkg::STATUS_ENQUEUED;
                            state_next  = lfnr_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = lfnr_pkg::STATUS_EXHAUSTED;
                            state_next  = lfnr_pkg::ST_DONE;
                        end
                    end
                    else if (qhead_reg == qtail_reg)
                    begin
                        status_next = lfnr_pkg::STATUS_EMPTY;
                        state_next  = lfnr_pkg::ST_DONE;
                    end
                    else
                    begin
                        link_en    = 1'b1;
                        link_addr  = qhead_reg;
                        state_next = lfnr_pkg::ST_LINK;
                    end
                end
            end

            lfnr_pkg::ST_LINK:
            begin
                if (mode_reg == lfnr_pkg::MODE_ENQUEUE)
                begin
                    value_en    = 1'b1;
                    value_we    = 1'b1;
                    value_addr  = fhead_reg;
                    value_wdata = val_reg;
                    link_en     = 1'b1;
                    link_we     = 1'b1;
                    link_addr   = qtail_reg;
                    link_wdata  = fhead_reg;
                    qtail_next  = fhead_reg;
                    fhead_next  = link_rdata_reg;
                    fcount_next = fcount_reg - CNT_W'(1);
                    reuse_next  = reuse_reg + 32'd1;
                    status_next = lfnr_pkg::STATUS_ENQUEUED;
                    state_next  = lfnr_pkg::ST_DONE;
                end
                else
                begin
                    link_en     = 1'b1;
                    link_we     = 1'b1;
                    link_addr   = ftail_reg;
                    link_wdata  = qhead_reg;
                    ftail_next  = qhead_reg;
                    qhead_next  = link_rdata_reg;
                    push_next   = push_reg + 32'd1;
                    fcount_next = fcount_inc;
                    if (fcount_inc > fmax_reg)
                    begin
                        fmax_next = fcount_inc;
                    end
                    value_en    = 1'b1;
                    value_addr  = link_rdata_reg;
                    state_next  = lfnr_pkg::ST_VALUE;
                end
            end

            lfnr_pkg::ST_VALUE:
            begin
                vout_next   = value_rdata_reg;
                status_next = lfnr_pkg::STATUS_DEQUEUED;
                state_next  = lfnr_pkg::ST_DONE;
            end

            lfnr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {3'b000, pop_reg, push_reg, reuse_reg,
                                     made_wide[CW-1:0], fmax_wide[CW-1:0],
                                     fcount_wide[CW-1:0], vout_wide[VW-1:0]};
                    state_next    = lfnr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lfnr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_free_within_made: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fcount_reg} + (CNT_W + 1)'(2)) <= {1'b0, made_reg})
        else $error("free list longer than the slots taken allow");

    a_peak_covers_length: assert property (@(posedge clk) disable iff (!rst_n)
        fmax_reg >= fcount_reg)
        else $error("free list peak below its current length");

    a_dequeue_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfnr_pkg::ST_LINK && mode_reg == lfnr_pkg::MODE_DEQUEUE)
        |-> (qhead_reg != qtail_reg))
        else $error("dequeue link read on an empty queue");

    a_enqueue_reuse_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfnr_pkg::ST_LINK && mode_reg == lfnr_pkg::MODE_ENQUEUE)
        |-> (fcount_reg != '0))
        else $error("free list reuse with no free node");
`endif

endmodule

`default_nettype wire

// ===== sim/lfnr_checker.sv =====
// Checker for the linked-list FIFO with node recycling: watches both stream channels,
// predicts each result word from its own copy of the lists and compares them field by field.
// Depends on lfnr_pkg for the status codes and the mode encoding.
`timescale 1ns / 1ps

module lfnr_checker
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [31:0]   s_tdata,
    input  wire logic [0:0]    s_tuser,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [151:0]  m_tdata,
    input  wire logic [1:0]    m_tuser,
    output int                 fail_count,
    output int                 pending
);

    localparam int NODE_SLOTS = 64;

    typedef struct packed {
        lfnr_pkg::status_t status;
        logic [31:0]       value_out;
        logic [6:0]        free_length;
        logic [6:0]        free_peak;
        logic [6:0]        nodes_made;
        logic [31:0]       nodes_reused;
        logic [31:0]       free_pushes;
        logic [31:0]       free_pops;
    } result_t;

    logic [5:0]  link_mem [NODE_SLOTS];
    logic [31:0] value_mem [NODE_SLOTS];
    logic        link_live [NODE_SLOTS];
    logic [5:0]  q_head;
    logic [5:0]  q_tail;
    logic [5:0]  f_head;
    logic [5:0]  f_tail;
    logic [6:0]  free_cnt;
    logic [6:0]  free_hi;
    logic [6:0]  made_cnt;
    logic [31:0] reuse_cnt;
    logic [31:0] push_cnt;
    logic [31:0] pop_cnt;

    result_t     pending_results [$];
    result_t     want;
    int          errors;

    task automatic clear_lists();
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            link_mem[i]  = '0;
            value_mem[i] = '0;
            link_live[i] = 1'b0;
        end
        q_head    = 6'd0;
        q_tail    = 6'd0;
        f_head    = 6'd1;
        f_tail    = 6'd1;
        free_cnt  = '0;
        free_hi   = '0;
        made_cnt  = 7'd2;
        reuse_cnt = '0;
        push_cnt  = '0;
        pop_cnt   = '0;
    endtask

    function automatic result_t next_fifo_result(input logic mode, input logic [31:0] value);
        result_t    r;
        logic [5:0] node;
        logic [5:0] old_head;
        logic [5:0] first;
        logic       have;
        r    = '0;
        node = '0;
        have = 1'b1;
        if (mode == lfnr_pkg::MODE_ENQUEUE)
        begin
            pop_cnt++;
            // The free list's sentinel is handed out and its successor takes over.
            if (link_live[f_head])
            begin
                node      = f_head;
                f_head    = link_mem[node];
                free_cnt  = free_cnt - 7'd1;
                reuse_cnt++;
            end
            else if (made_cnt < NODE_SLOTS)
            begin
                node     = made_cnt[5:0];
                made_cnt = made_cnt + 7'd1;
            end
            else
            begin
                have = 1'b0;
            end
            if (have)
            begin
                link_live[node]   = 1'b0;
                value_mem[node]   = value;
                link_mem[q_tail]  = node;
                link_live[q_tail] = 1'b1;
                q_tail            = node;
                r.status          = lfnr_pkg::STATUS_ENQUEUED;
            end
            else
            begin
                r.status = lfnr_pkg::STATUS_EXHAUSTED;
            end
        end
        else
        begin
            old_head = q_head;
            if (!link_live[old_head])
            begin
                r.status = lfnr_pkg::STATUS_EMPTY;
            end
            else
            begin
                first       = link_mem[old_head];
                r.value_out = value_mem[first];
                q_head      = first;
                if (q_tail == old_head)
                    q_tail = first;
                push_cnt++;
                link_live[old_head] = 1'b0;
                link_mem[f_tail]    = old_head;
                link_live[f_tail]   = 1'b1;
                f_tail              = old_head;
                free_cnt            = free_cnt + 7'd1;
                if (free_cnt > free_hi)
                    free_hi = free_cnt;
                r.status = lfnr_pkg::STATUS_DEQUEUED;
            end
        end
        r.free_length  = free_cnt;
        r.free_peak    = free_hi;
        r.nodes_made   = made_cnt;
        r.nodes_reused = reuse_cnt;
        r.free_pushes  = push_cnt;
        r.free_pops    = pop_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (act !== exp)
        begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lists();
            pending_results.delete();
            errors = 0;
        end
        else
        begin
            // A word leaving in the same cycle always belongs to an earlier input word.
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no expectation: tuser %0h tdata %0h",
                           m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("value_out", want.value_out, m_tdata[31:0]);
                    check_field("free_length", 32'(want.free_length), 32'(m_tdata[38:32]));
                    check_field("free_peak", 32'(want.free_peak), 32'(m_tdata[45:39]));
                    check_field("nodes_made", 32'(want.nodes_made), 32'(m_tdata[52:46]));
                    check_field("nodes_reused", want.nodes_reused, m_tdata[84:53]);
                    check_field("free_pushes", want.free_pushes, m_tdata[116:85]);
                    check_field("free_pops", want.free_pops, m_tdata[148:117]);
                    check_field("zero_fill", 32'd0, 32'(m_tdata[151:149]));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(next_fifo_result(s_tuser[0], s_tdata));
        end
        fail_count <= errors;
        pending    <= pending_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the testbench for linked_fifo_with_node_recycling_core: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on lfnr_pkg and on lfnr_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 434;
    localparam int RUN_LENGTH   = 66;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [31:0]    s_tdata = '0;
    logic [0:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [151:0]   m_tdata;
    logic [1:0]     m_tuser;

    int             fail_count;
    int             pending;
    int             send_idle = 23;
    int             recv_idle = 71;
    int             cycle_count = 0;
    int             words_sent;

    linked_fifo_with_node_recycling_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lfnr_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[linked_fifo_with_node_recycling_core] ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic mode, input logic [31:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 32'h0000_0000;
        else if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Long enqueue runs fill the pool to exhaustion, long dequeue runs drain the queue
    // and recycle its nodes, and short mixed runs interleave the two.
    task automatic random_phase(input int count);
        int kind;
        int len;
        int enq_share;
        words_sent = 0;
        while (words_sent < count)
        begin
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                repeat (RUN_LENGTH)
                    send_word(lfnr_pkg::MODE_ENQUEUE, pick_value());
            end
            else if (kind < 4)
            begin
                repeat (RUN_LENGTH)
                    send_word(lfnr_pkg::MODE_DEQUEUE, $urandom);
            end
            else
            begin
                len       = $urandom_range(10, 40);
                enq_share = $urandom_range(20, 80);
                repeat (len)
                begin
                    if ($urandom_range(99) < enq_share)
                        send_word(lfnr_pkg::MODE_ENQUEUE, pick_value());
                    else
                        send_word(lfnr_pkg::MODE_DEQUEUE, $urandom);
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(lfnr_pkg::MODE_DEQUEUE, 32'hFFFF_FFFF);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'h0000_0000);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'hFFFF_FFFF);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'h8000_0001);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'h5555_5555);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'hAAAA_AAAA);
        repeat (6)
            send_word(lfnr_pkg::MODE_DEQUEUE, $urandom);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'h1234_5678);
        send_word(lfnr_pkg::MODE_ENQUEUE, 32'h0000_FFFF);
        send_word(lfnr_pkg::MODE_DEQUEUE, 32'h0000_0000);
        send_word(lfnr_pkg::MODE_DEQUEUE, 32'hFFFF_FFFF);
        send_word(lfnr_pkg::MODE_DEQUEUE, $urandom);

        random_phase(PHASE_WORDS);
        send_idle = 71;
        recv_idle = 23;
        random_phase(PHASE_WORDS);
        send_idle = 0;
        recv_idle = 0;
        random_phase(PHASE_WORDS);
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[linked_fifo_with_node_recycling_core] OK");
        else
            $display("[linked_fifo_with_node_recycling_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lfnr_pkg.sv
src/linked_fifo_with_node_recycling_core.sv
sim/lfnr_checker.sv
sim/tb_top.sv
